>>> rtl/tdpe_pkg.sv
// ----------------------------------------------------------------------------
// tdpe_pkg
// Shared types and codes for the Thumb data-processing execute block.
// ----------------------------------------------------------------------------
package tdpe_pkg;

    // Operation codes carried in req_type
    typedef enum logic [2:0] {
        OP_ADD_IMM = 3'd0,
        OP_SUB_IMM = 3'd1,
        OP_CMP_IMM = 3'd2,
        OP_MOV_IMM = 3'd3,
        OP_MOV_REG = 3'd4,
        OP_MUL     = 3'd5
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FORBIDDEN = 2'd1,
        ST_UNKNOWN   = 2'd2
    } status_t;

    // Encoding numbers
    localparam logic [2:0] ENC_T1 = 3'd1;
    localparam logic [2:0] ENC_T2 = 3'd2;
    localparam logic [2:0] ENC_T3 = 3'd3;
    localparam logic [2:0] ENC_T4 = 3'd4;

    // Special register indexes
    localparam logic [3:0] REG_SP = 4'd13;
    localparam logic [3:0] REG_PC = 4'd15;

    localparam int unsigned NUM_REGS = 16;

    // One decoded instruction
    typedef struct packed {
        logic [2:0]  req_type;
        logic [2:0]  encoding;
        logic [3:0]  dest_reg;
        logic [3:0]  src_reg;
        logic [3:0]  src2_reg;
        logic [31:0] immediate;
        logic        ext_bit;
    } req_t;

    // One execute result
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] write_value;
        logic [3:0]  dest_index;
        logic        wrote_reg;
        logic [3:0]  flags_nzcv;
    } res_t;

endpackage

>>> rtl/tdpe_if.sv
// ----------------------------------------------------------------------------
// tdpe_if
// Valid/ready channels for instruction requests and execute results.
// ----------------------------------------------------------------------------

// Instruction request channel
interface tdpe_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [2:0]  encoding;
    logic [3:0]  dest_reg;
    logic [3:0]  src_reg;
    logic [3:0]  src2_reg;
    logic [31:0] immediate;
    logic        ext_bit;

    modport source (
        output valid, req_type, encoding, dest_reg, src_reg, src2_reg, immediate, ext_bit,
        input  ready
    );
    modport sink (
        input  valid, req_type, encoding, dest_reg, src_reg, src2_reg, immediate, ext_bit,
        output ready
    );
endinterface

// Result channel
interface tdpe_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] write_value;
    logic [3:0]  dest_index;
    logic        wrote_reg;
    logic [3:0]  flags_nzcv;

    modport source (
        output valid, status, write_value, dest_index, wrote_reg, flags_nzcv,
        input  ready
    );
    modport sink (
        input  valid, status, write_value, dest_index, wrote_reg, flags_nzcv,
        output ready
    );
endinterface

>>> rtl/tdpe_alu.sv
// ----------------------------------------------------------------------------
// tdpe_alu
// Encoding checks, adder, multiplier and flag rules for one instruction.
// ----------------------------------------------------------------------------
module tdpe_alu
    import tdpe_pkg::*;
(
    input  req_t        rq,
    input  logic [31:0] op_n,
    input  logic [31:0] op_m,
    input  logic [3:0]  flags,
    output res_t        res
);

    // SP, LR or PC
    function automatic logic is_high(input logic [3:0] r);
        return r >= REG_SP;
    endfunction

    logic        sub_mode;
    logic [31:0] addend;
    logic [32:0] sum;
    logic        add_c;
    logic        add_v;
    logic [31:0] prod;
    logic [7:0]  imm_b;
    logic [7:0]  imm_h;
    logic        unrotated;
    logic        exp_c;
    logic [3:0]  d_mov;
    logic [31:0] mov_val;
    status_t     st;
    logic        fl;

    // Shared adder: subtract and compare add NOT immediate plus one
    assign sub_mode = (rq.req_type != OP_ADD_IMM);
    assign addend   = sub_mode ? ~rq.immediate : rq.immediate;
    assign sum      = {1'b0, op_n} + {1'b0, addend} + {32'd0, sub_mode};
    assign add_c    = sum[32];
    assign add_v    = (op_n[31] ^ sum[31]) & (addend[31] ^ sum[31]);

    // Multiplier, low word only
    assign prod = op_n * op_m;

    // Carry out of the immediate expansion
    assign imm_b     = rq.immediate[7:0];
    assign imm_h     = rq.immediate[15:8];
    assign unrotated = (rq.immediate == {24'd0, imm_b})
                    || (rq.immediate == {8'd0, imm_b, 8'd0, imm_b})
                    || (rq.immediate == {imm_h, 8'd0, imm_h, 8'd0})
                    || (rq.immediate == {imm_b, imm_b, imm_b, imm_b});
    assign exp_c     = unrotated ? flags[1] : rq.immediate[31];

    // T1 register move: D bit selects the high bank
    assign d_mov   = rq.ext_bit ? {1'b1, rq.dest_reg[2:0]} : rq.dest_reg;
    // Writes to PC clear bit 0
    assign mov_val = (d_mov == REG_PC) ? {op_m[31:1], 1'b0} : op_m;

    // Checks, results and flag updates per operation
    always_comb
    begin
        res            = '0;
        res.flags_nzcv = flags;
        st             = ST_OK;
        fl             = 1'b0;
        unique case (rq.req_type)
            OP_ADD_IMM, OP_SUB_IMM:
            begin
                unique case (rq.encoding)
                    ENC_T1, ENC_T2: fl = 1'b1;
                    ENC_T3:
                    begin
                        if (rq.dest_reg == REG_SP || rq.dest_reg == REG_PC ||
                            rq.src_reg == REG_SP || rq.src_reg == REG_PC)
                            st = ST_FORBIDDEN;
                        fl = rq.ext_bit;
                    end
                    ENC_T4:
                    begin
                        if (rq.src_reg == REG_SP || rq.src_reg == REG_PC ||
                            is_high(rq.dest_reg))
                            st = ST_FORBIDDEN;
                    end
                    default: st = ST_UNKNOWN;
                endcase
                if (st == ST_OK)
                begin
                    res.write_value = sum[31:0];
                    res.dest_index  = rq.dest_reg;
                    res.wrote_reg   = 1'b1;
                    if (fl)
                        res.flags_nzcv = {sum[31], sum[31:0] == 32'd0, add_c, add_v};
                end
            end
            OP_CMP_IMM:
            begin
                unique case (rq.encoding)
                    ENC_T1: st = ST_OK;
                    ENC_T2:
                    begin
                        if (rq.src_reg == REG_PC)
                            st = ST_FORBIDDEN;
                    end
                    default: st = ST_UNKNOWN;
                endcase
                if (st == ST_OK)
                begin
                    res.write_value = sum[31:0];
                    res.flags_nzcv  = {sum[31], sum[31:0] == 32'd0, add_c, add_v};
                end
            end
            OP_MOV_IMM:
            begin
                unique case (rq.encoding)
                    ENC_T1: fl = 1'b1;
                    ENC_T2:
                    begin
                        if (is_high(rq.dest_reg))
                            st = ST_FORBIDDEN;
                        fl = rq.ext_bit;
                    end
                    ENC_T3:
                    begin
                        if (is_high(rq.dest_reg))
                            st = ST_FORBIDDEN;
                    end
                    default: st = ST_UNKNOWN;
                endcase
                if (st == ST_OK)
                begin
                    res.write_value = rq.immediate;
                    res.dest_index  = rq.dest_reg;
                    res.wrote_reg   = 1'b1;
                    if (fl)
                    begin
                        res.flags_nzcv[3] = rq.immediate[31];
                        res.flags_nzcv[2] = (rq.immediate == 32'd0);
                        // T1 keeps C, T2 takes the expansion carry
                        if (rq.encoding == ENC_T2)
                            res.flags_nzcv[1] = exp_c;
                    end
                end
            end
            OP_MOV_REG:
            begin
                unique case (rq.encoding)
                    ENC_T1:
                    begin
                        st = ST_OK;
                    end
                    ENC_T2: fl = 1'b1;
                    ENC_T3:
                    begin
                        fl = rq.ext_bit;
                        if (rq.ext_bit && (is_high(rq.dest_reg) || is_high(rq.src2_reg)))
                            st = ST_FORBIDDEN;
                        if (!rq.ext_bit && (rq.dest_reg == REG_PC || rq.src2_reg == REG_PC ||
                            (rq.dest_reg == REG_SP && rq.src2_reg == REG_SP)))
                            st = ST_FORBIDDEN;
                    end
                    default: st = ST_UNKNOWN;
                endcase
                if (st == ST_OK)
                begin
                    // Only T1 honours the D bit
                    if (rq.encoding == ENC_T1)
                    begin
                        res.write_value = mov_val;
                        res.dest_index  = d_mov;
                    end
                    else
                    begin
                        res.write_value = (rq.dest_reg == REG_PC) ? {op_m[31:1], 1'b0} : op_m;
                        res.dest_index  = rq.dest_reg;
                        if (fl && rq.dest_reg != REG_PC)
                        begin
                            res.flags_nzcv[3] = op_m[31];
                            res.flags_nzcv[2] = (op_m == 32'd0);
                        end
                    end
                    res.wrote_reg = 1'b1;
                end
            end
            OP_MUL:
            begin
                unique case (rq.encoding)
                    ENC_T1: fl = 1'b1;
                    ENC_T2:
                    begin
                        if (is_high(rq.dest_reg) || is_high(rq.src_reg) || is_high(rq.src2_reg))
                            st = ST_FORBIDDEN;
                    end
                    default: st = ST_UNKNOWN;
                endcase
                if (st == ST_OK)
                begin
                    res.write_value = prod;
                    res.dest_index  = rq.dest_reg;
                    res.wrote_reg   = 1'b1;
                    if (fl)
                    begin
                        res.flags_nzcv[3] = prod[31];
                        res.flags_nzcv[2] = (prod == 32'd0);
                    end
                end
            end
            default: st = ST_UNKNOWN;
        endcase
        res.status = st;
    end

endmodule

>>> rtl/thumb_data_processing_execute.sv
// ----------------------------------------------------------------------------
// thumb_data_processing_execute
// Execute stage for Thumb add/sub/cmp/mov/mul with a 16 x 32 register file.
// ----------------------------------------------------------------------------
// Request to result valid: the execute-stage register, then the output register.
// Throughput: one request per cycle unless res.ready stalls; the register file
// read and execute overlap, with write data forwarded to the next request.
// Reset: flags cleared; every register reads as zero until first written
// (per-entry valid bits, no clearing pass); output and pipeline empty.
module thumb_data_processing_execute
    import tdpe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tdpe_req_if.sink   req,
    tdpe_res_if.source res
);

    // Register file storage
    logic [31:0]         rf_mem [NUM_REGS];
    logic [NUM_REGS-1:0] rf_vld_reg;

    // Read stage
    logic        req_acc;
    logic [3:0]  rd_m_addr;
    logic [31:0] rd_n_reg;
    logic [31:0] rd_m_reg;
    logic        rvld_n_reg;
    logic        rvld_m_reg;
    logic        fwd_n_reg;
    logic        fwd_m_reg;
    logic        fwd_n_next;
    logic        fwd_m_next;
    req_t        req_in;

    // Execute stage
    logic        s1_valid_reg;
    req_t        s1_req_reg;
    logic        s1_adv;
    logic [31:0] op_n;
    logic [31:0] op_m;
    res_t        alu_res;
    logic        wr_en;
    logic [31:0] wlast_reg;

    // Output and architectural flags
    logic        out_valid_reg;
    res_t        out_res_reg;
    logic [3:0]  flags_reg;

    // Handshakes
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready = !s1_valid_reg || s1_adv;
    assign req_acc   = req.valid && req.ready;
    assign wr_en     = s1_adv && alu_res.wrote_reg;

    // Request payload bundle
    assign req_in = '{req_type:  req.req_type,
                      encoding:  req.encoding,
                      dest_reg:  req.dest_reg,
                      src_reg:   req.src_reg,
                      src2_reg:  req.src2_reg,
                      immediate: req.immediate,
                      ext_bit:   req.ext_bit};

    // T1 multiply reads d as its second operand
    assign rd_m_addr = (req.req_type == OP_MUL && req.encoding == ENC_T1) ?
                       req.dest_reg : req.src2_reg;

    // Forward when the register being read is written at the same edge
    assign fwd_n_next = wr_en && (alu_res.dest_index == req.src_reg);
    assign fwd_m_next = wr_en && (alu_res.dest_index == rd_m_addr);

    // Memory read and write ports
    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            rd_n_reg   <= rf_mem[req.src_reg];
            rd_m_reg   <= rf_mem[rd_m_addr];
            rvld_n_reg <= rf_vld_reg[req.src_reg];
            rvld_m_reg <= rf_vld_reg[rd_m_addr];
            fwd_n_reg  <= fwd_n_next;
            fwd_m_reg  <= fwd_m_next;
            s1_req_reg <= req_in;
        end
        if (wr_en)
        begin
            rf_mem[alu_res.dest_index] <= alu_res.write_value;
            wlast_reg                  <= alu_res.write_value;
        end
        if (s1_adv)
            out_res_reg <= alu_res;
    end

    // Entry valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rf_vld_reg <= '0;
        else if (wr_en)
            rf_vld_reg[alu_res.dest_index] <= 1'b1;
    end

    // Operand selection: forwarded, stored or reset value
    assign op_n = fwd_n_reg ? wlast_reg : (rvld_n_reg ? rd_n_reg : 32'd0);
    assign op_m = fwd_m_reg ? wlast_reg : (rvld_m_reg ? rd_m_reg : 32'd0);

    tdpe_alu u_alu (
        .rq    (s1_req_reg),
        .op_n  (op_n),
        .op_m  (op_m),
        .flags (flags_reg),
        .res   (alu_res)
    );

    // Pipeline control and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            if (req.ready)
                s1_valid_reg <= req.valid;
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                flags_reg     <= alu_res.flags_nzcv;
            end
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result channel
    assign res.valid       = out_valid_reg;
    assign res.status      = out_res_reg.status;
    assign res.write_value = out_res_reg.write_value;
    assign res.dest_index  = out_res_reg.dest_index;
    assign res.wrote_reg   = out_res_reg.wrote_reg;
    assign res.flags_nzcv  = out_res_reg.flags_nzcv;

endmodule
